>>> src/stable_priority_queue_rekey_defines.svh
// assertion macros for the priority queue block
// no dependencies
`ifndef STABLE_PRIORITY_QUEUE_REKEY_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_REKEY_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SPQ_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_R(label, clk, prop)
`endif
`endif

>>> src/spq_pkg.sv
// types and codes shared by the priority queue controller and datapath
// no dependencies
package spq_pkg;
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXTRACT = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;
  localparam logic [1:0] REQ_BOOST   = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_BOOST = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_REINS, S_OUT} state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic reinsert;
  } cmd_t;

  typedef struct packed {
    logic       need_reinsert;
  } stat_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] level;
    logic [15:0]        arrival;
    logic               bst;
  } entry_t;
endpackage

>>> src/spq_ctrl.sv
// controller state machine for the priority queue
// depends on spq_pkg
module spq_ctrl import spq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.exec    = 1'b1;
          state_next  = stat.need_reinsert ? S_REINS : S_OUT;
        end
      end
      S_REINS: begin
        cmd.reinsert = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> src/spq_dp.sv
// slot array, search and shift datapath of the priority queue
// depends on spq_pkg
module spq_dp import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         req_type,
  input  logic [15:0]        player_id,
  input  logic signed [15:0] entry_level,
  input  logic [15:0]        arrival_rank,
  input  logic               boostable,
  input  logic signed [15:0] boost_amount,
  output logic [1:0]         status,
  output logic [15:0]        out_id,
  output logic signed [15:0] out_level,
  output logic [15:0]        out_arrival,
  output logic               out_boostable,
  output logic [4:0]         occupancy,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  entry_t slot [DEPTH];
  logic [CW-1:0] n;
  entry_t hold;

  // first match and insert position masks
  logic [DEPTH-1:0] match, before_ins;
  logic [DEPTH-1:0] found_m;
  logic             found;
  entry_t           hit, ins_e;
  logic signed [16:0] sum;
  logic signed [15:0] sat;

  always_comb begin
    ins_e = cmd.reinsert ? hold : entry_t'{player_id, entry_level, arrival_rank, boostable};
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CW'(i) < n) &&
                 ((req_type == REQ_EXTRACT) ? (i == 0) : (slot[i].id == player_id));
      before_ins[i] = (CW'(i) < n) && ((slot[i].level > ins_e.level) ||
                      (slot[i].level == ins_e.level && slot[i].arrival <= ins_e.arrival));
    end
    found_m = match & ~(match - 1'b1);
    found   = |match;
    hit     = '0;
    for (int i = 0; i < DEPTH; i++) if (found_m[i]) hit = slot[i];
    sum = 17'(hit.level) + 17'(boost_amount);
    if (sum > 17'sd32767)       sat = 16'sh7fff;
    else if (sum < -17'sd32768) sat = 16'sh8000;
    else                        sat = sum[15:0];
    stat.need_reinsert = (req_type == REQ_BOOST) && found && hit.bst;
  end

  logic [DEPTH-1:0] after_rm;
  assign after_rm = found_m - 1'b1;  // low bits below the hit

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.exec) begin
      status <= ST_MISSING;
      {out_id, out_level, out_arrival, out_boostable} <= '0;
      unique case (req_type)
        REQ_INSERT: begin
          if (n == DEPTH_C) status <= ST_FULL;
          else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (!before_ins[i]) begin
                if (i == 0 || before_ins[i-1]) slot[i] <= ins_e;
                else slot[i] <= slot[i-1];
              end
            end
            n <= n + 1'b1;
            status <= ST_DONE;
            {out_id, out_level, out_arrival, out_boostable} <= ins_e;
          end
        end
        REQ_EXTRACT, REQ_REMOVE, REQ_BOOST: begin
          if (found) begin
            {out_id, out_level, out_arrival, out_boostable} <= hit;
            if (req_type == REQ_BOOST && !hit.bst) status <= ST_NO_BOOST;
            else begin
              status <= ST_DONE;
              for (int i = 0; i < DEPTH - 1; i++)
                if (!after_rm[i]) slot[i] <= slot[i+1];
              n <= n - 1'b1;
              hold <= entry_t'{hit.id, sat, hit.arrival, hit.bst};
              if (req_type == REQ_BOOST) out_level <= sat;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.reinsert) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!before_ins[i]) begin
          if (i == 0 || before_ins[i-1]) slot[i] <= ins_e;
          else slot[i] <= slot[i-1];
        end
      end
      n <= n + 1'b1;
    end
  end

  assign occupancy = 5'(n);
  assign count = n;
endmodule

>>> src/stable_priority_queue_rekey.sv
// Sorted priority queue of DEPTH entries, highest level first, ties by lower
// arrival rank. A request is taken only while the queue is idle and its result
// is offered the next cycle, or after the re-insert state for a boost of a
// boostable entry, and held until transferred, with the input stalled meanwhile;
// the re-insert state passes the boosted entry over the shift register of slots.
// Depends on spq_pkg, spq_ctrl, spq_dp.
`include "stable_priority_queue_rekey_defines.svh"
module stable_priority_queue_rekey import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [15:0]        player_id,
  input  logic signed [15:0] entry_level,
  input  logic [15:0]        arrival_rank,
  input  logic               boostable,
  input  logic signed [15:0] boost_amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [15:0]        out_id,
  output logic signed [15:0] out_level,
  output logic [15:0]        out_arrival,
  output logic               out_boostable,
  output logic [4:0]         occupancy
);
  cmd_t  cmd;
  stat_t stat;
  logic [$clog2(DEPTH+1)-1:0] count;

  spq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  spq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat, .req_type, .player_id, .entry_level, .arrival_rank,
    .boostable, .boost_amount, .status, .out_id, .out_level, .out_arrival,
    .out_boostable, .occupancy, .count
  );

  `SPQ_ASSERT(a_cap, clk, rst, (count <= ($clog2(DEPTH+1))'(DEPTH)))
  `SPQ_ASSERT(a_busy, clk, rst, (out_valid |-> in_stall))
  `SPQ_ASSERT(a_seq, clk, rst, ((in_valid && !in_stall) |=> in_stall))
endmodule
